FILE: hw/rtl/windowed_sample_history_aggregator_unit_defines.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef WINDOWED_SAMPLE_HISTORY_AGGREGATOR_UNIT_DEFINES_SVH
`define WINDOWED_SAMPLE_HISTORY_AGGREGATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define WSHA_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define WSHA_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wsha_pkg.sv
package wsha_pkg;

  // Field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned ENT_W   = 3;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned FPOS_W  = 12;
  localparam int unsigned EPOS_W  = 13;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned HLEN_W  = 13;
  localparam int unsigned SCNT_W  = 13;

  // Defaults
  localparam int unsigned DEPTH_DEF    = 4096;
  localparam int unsigned ENTITIES_DEF = 8;
  localparam logic [HLEN_W-1:0] HLEN_RST = 13'd4096;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN  = 2'd0,
    MODE_STORE = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    AGG_MIN   = 3'd0,
    AGG_MAX   = 3'd1,
    AGG_AVG   = 3'd2,
    AGG_FIRST = 3'd3,
    AGG_LAST  = 3'd4
  } agg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_STWR,
    S_MOD,
    S_RD,
    S_ACC,
    S_POST,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [TS_W-1:0]         timestamp;
    logic [ENT_W-1:0]        entity;
    logic signed [VAL_W-1:0] sample_value;
    logic [FPOS_W-1:0]       first_pos;
    logic [EPOS_W-1:0]       end_pos;
    logic [KIND_W-1:0]       agg_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    found;
    logic [TS_W-1:0]         window_time;
    logic [SCNT_W-1:0]       stored_count;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;
    logic latch;
    logic open;
    logic store_rd;
    logic store_wr;
    logic close;
    logic q_init;
    logic mod_step;
    logic rd;
    logic acc;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic  clear_last;
    mode_e mode;
    logic  wrapped;
    logic  mod_last;
    logic  more;
    logic  need_div;
    logic  div_last;
    logic  out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/wsha_in_if.sv
interface wsha_in_if;
  import wsha_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [TS_W-1:0]         timestamp;
  logic [ENT_W-1:0]        entity;
  logic signed [VAL_W-1:0] sample_value;
  logic [FPOS_W-1:0]       first_pos;
  logic [EPOS_W-1:0]       end_pos;
  logic [KIND_W-1:0]       agg_kind;

  modport source (
    output valid, mode, timestamp, entity, sample_value, first_pos, end_pos, agg_kind,
    input  ready
  );
  modport sink (
    input  valid, mode, timestamp, entity, sample_value, first_pos, end_pos, agg_kind,
    output ready
  );
endinterface

FILE: hw/rtl/wsha_out_if.sv
interface wsha_out_if;
  import wsha_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic                    found;
  logic [TS_W-1:0]         window_time;
  logic [SCNT_W-1:0]       stored_count;

  modport source (
    output valid, result_value, found, window_time, stored_count,
    input  ready
  );
  modport sink (
    input  valid, result_value, found, window_time, stored_count,
    output ready
  );
endinterface

FILE: hw/rtl/windowed_sample_history_aggregator_unit.sv
// Windowed sample history aggregator.
// Input channel in_i carries one transaction per command: open a sample slot,
// store an entity value, close a sample, or query a window. Only a query
// produces an output transaction on out_o (value, found, window time, count).
// The user must write the history length register through cfg_we_i/cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// One transaction is worked at a time. A store is a read-modify-write of the
// slot's valid row. A query finds the oldest-slot remainder once the history
// has wrapped, walks the window, and runs the shift-subtract divider when the
// average is asked for. The window walk reads each slot through the
// registered memory ports and accumulates it before reading the next one.
// After reset the block clears the valid rows and timestamps, one slot per
// cycle across all DEPTH slots, with in_i.ready low.
// A finished query result sits in the output register; while the receiver
// stalls the block holds it and does not take a new query result.
module windowed_sample_history_aggregator_unit #(
  parameter int unsigned DEPTH    = wsha_pkg::DEPTH_DEF,
  parameter int unsigned ENTITIES = wsha_pkg::ENTITIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wsha_pkg::HLEN_W-1:0] cfg_wdata_i,
  wsha_in_if.sink                     in_i,
  wsha_out_if.source                  out_o
);
  import wsha_pkg::*;

  `include "windowed_sample_history_aggregator_unit_defines.svh"

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  item;
  out_item_t res;

  // Input payload
  always_comb begin
    item.mode         = in_i.mode;
    item.timestamp    = in_i.timestamp;
    item.entity       = in_i.entity;
    item.sample_value = in_i.sample_value;
    item.first_pos    = in_i.first_pos;
    item.end_pos      = in_i.end_pos;
    item.agg_kind     = in_i.agg_kind;
  end

  wsha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsha_dp #(
    .DEPTH    (DEPTH),
    .ENTITIES (ENTITIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready)
  );

  // Output payload
  assign out_o.result_value = res.result_value;
  assign out_o.found        = res.found;
  assign out_o.window_time  = res.window_time;
  assign out_o.stored_count = res.stored_count;

  // Checks
  `WSHA_ASSERT_NXT(a_one_at_a_time, in_i.valid && in_i.ready, !in_i.ready, "input taken while busy")
  `WSHA_ASSERT_IMP(a_load_no_clobber, cmd.out_load, !(out_o.valid && !out_o.ready), "result overwritten")
  `WSHA_ASSERT_IMP(a_valid_from_load, $rose(out_o.valid), $past(cmd.out_load), "result without load")

endmodule

FILE: hw/rtl/wsha_ctrl.sv
module wsha_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wsha_pkg::sts_t  sts_i,
  output wsha_pkg::cmd_t  cmd_o
);
  import wsha_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.mode)
          MODE_OPEN: begin
            cmd_o.open = 1'b1;
            state_d    = S_IDLE;
          end
          MODE_STORE: begin
            cmd_o.store_rd = 1'b1;
            state_d        = S_STWR;
          end
          MODE_CLOSE: begin
            cmd_o.close = 1'b1;
            state_d     = S_IDLE;
          end
          MODE_QUERY: begin
            cmd_o.q_init = 1'b1;
            state_d      = sts_i.wrapped ? S_MOD : S_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_STWR: begin
        cmd_o.store_wr = 1'b1;
        state_d        = S_IDLE;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.more ? S_RD : S_POST;
      end
      S_POST: begin
        if (sts_i.need_div) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/wsha_dp.sv
module wsha_dp #(
  parameter int unsigned DEPTH    = wsha_pkg::DEPTH_DEF,
  parameter int unsigned ENTITIES = wsha_pkg::ENTITIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wsha_pkg::HLEN_W-1:0]     cfg_wdata_i,
  input  wsha_pkg::in_item_t              item_i,
  input  wsha_pkg::cmd_t                  cmd_i,
  output wsha_pkg::sts_t                  sts_o,
  output wsha_pkg::out_item_t             out_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i
);
  import wsha_pkg::*;

  localparam int unsigned SW      = $clog2(DEPTH);
  localparam int unsigned LW      = $clog2(DEPTH + 1);
  localparam int unsigned AW      = $clog2(DEPTH * ENTITIES);
  localparam int unsigned PW      = (LW > 13) ? LW : 13;
  localparam int unsigned XW      = ((SW > 12) ? SW : 12) + 2;
  localparam int unsigned SUMW    = VAL_W + LW;
  localparam int unsigned MCW     = $clog2(XW + 1);
  localparam int unsigned DCW     = $clog2(SUMW + 1);
  localparam int unsigned RST_LEN = (DEPTH < 4096) ? DEPTH : 4096;

  // Storage
  logic [ENTITIES-1:0] valid_mem [DEPTH];
  logic [TS_W-1:0]     time_mem  [DEPTH];
  logic [VAL_W-1:0]    val_mem   [DEPTH*ENTITIES];

  // Control registers
  logic [HLEN_W-1:0] hist_len_q;
  logic [SW-1:0]     ws_q, ws_d;
  logic [LW-1:0]     closed_q, closed_d;
  logic [SW-1:0]     clr_q;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  in_item_t               it_q;
  logic [SW-1:0]          slot_q, slot_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic                   tflag_q, tflag_d;
  logic [XW-1:0]          mdvd_q, mdvd_d;
  logic [LW-1:0]          mrem_q, mrem_d;
  logic [MCW-1:0]         mcnt_q, mcnt_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic [LW-1:0]          cnt_q, cnt_d;
  logic [VAL_W-1:0]       mn_q, mn_d, mx_q, mx_d, fv_q, fv_d, lv_q, lv_d;
  logic [SUMW-1:0]        ddvd_q, ddvd_d;
  logic [LW-1:0]          drem_q, drem_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   dneg_q, dneg_d;
  logic [TS_W-1:0]        wtime_q, wtime_d;
  out_item_t              out_q, out_d;

  // Memory read registers
  logic [ENTITIES-1:0] vrow_q;
  logic [TS_W-1:0]     trd_q;
  logic [VAL_W-1:0]    vval_q;

  // Derived values
  logic [LW-1:0]       len;
  logic [LW-1:0]       ws_inc, sl_inc;
  logic [SW-1:0]       ws_nxt, slot_nxt, rd_slot;
  logic [PW-1:0]       stop;
  logic                ent_ok, in_win, vbit, take, first_in;
  logic [ENTITIES-1:0] vsh;
  logic [AW-1:0]       vraddr, vwaddr;
  logic [LW:0]         mt, dt;
  logic                dge;
  logic [VAL_W-1:0]    quo, avg;
  logic                vwe;
  logic [SW-1:0]       vaddr_w;
  logic [ENTITIES-1:0] vdata_w;

  // Effective history length
  always_comb begin
    if (hist_len_q == '0) begin
      len = LW'(1);
    end else if (int'(hist_len_q) > int'(DEPTH)) begin
      len = LW'(DEPTH);
    end else begin
      len = LW'(hist_len_q);
    end
  end

  assign ws_inc   = LW'(ws_q) + LW'(1);
  assign ws_nxt   = (ws_inc >= len) ? '0 : SW'(ws_inc);
  assign sl_inc   = LW'(slot_q) + LW'(1);
  assign slot_nxt = (sl_inc == len) ? '0 : SW'(sl_inc);
  assign stop     = (PW'(it_q.end_pos) < PW'(len)) ? PW'(it_q.end_pos) : PW'(len);
  assign ent_ok   = int'(it_q.entity) < int'(ENTITIES);
  assign in_win   = pos_q < stop;
  assign vsh      = vrow_q >> it_q.entity;
  assign vbit     = vsh[0];
  assign take     = in_win && ent_ok && vbit;
  assign first_in = PW'(it_q.first_pos) < PW'(len);
  assign rd_slot  = cmd_i.rd ? slot_q : ws_q;
  assign vraddr   = AW'(slot_q) * AW'(ENTITIES) + AW'(it_q.entity);
  assign vwaddr   = AW'(ws_q) * AW'(ENTITIES) + AW'(it_q.entity);

  // Remainder and divider steps
  assign mt  = ({1'b0, mrem_q, mdvd_q[XW-1]} >= {1'b0, len}) ?
               ({mrem_q, mdvd_q[XW-1]} - {1'b0, len}) : {mrem_q, mdvd_q[XW-1]};
  assign dge = {drem_q, ddvd_q[SUMW-1]} >= {1'b0, cnt_q};
  assign dt  = dge ? ({drem_q, ddvd_q[SUMW-1]} - {1'b0, cnt_q}) : {drem_q, ddvd_q[SUMW-1]};
  assign quo = ddvd_q[VAL_W-1:0];
  assign avg = dneg_q ? (~quo + VAL_W'(1)) : quo;

  // Status
  always_comb begin
    sts_o            = '0;
    sts_o.clear_last = clr_q == SW'(DEPTH - 1);
    sts_o.mode       = mode_e'(it_q.mode);
    sts_o.wrapped    = closed_q >= len;
    sts_o.mod_last   = mcnt_q == MCW'(1);
    sts_o.more       = (pos_q + PW'(1)) < stop;
    sts_o.need_div   = (it_q.agg_kind == AGG_AVG) && (cnt_q != '0);
    sts_o.div_last   = dcnt_q == DCW'(1);
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // Datapath next state
  always_comb begin
    ws_d        = ws_q;
    closed_d    = closed_q;
    out_valid_d = out_valid_q;
    slot_d      = slot_q;
    pos_d       = pos_q;
    tflag_d     = tflag_q;
    mdvd_d      = mdvd_q;
    mrem_d      = mrem_q;
    mcnt_d      = mcnt_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    mn_d        = mn_q;
    mx_d        = mx_q;
    fv_d        = fv_q;
    lv_d        = lv_q;
    ddvd_d      = ddvd_q;
    drem_d      = drem_q;
    dcnt_d      = dcnt_q;
    dneg_d      = dneg_q;
    wtime_d     = wtime_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    if (cmd_i.open) ws_d = ws_nxt;
    if (cmd_i.close && (closed_q < LW'(DEPTH))) closed_d = closed_q + LW'(1);

    // Query start
    if (cmd_i.q_init) begin
      pos_d   = PW'(it_q.first_pos);
      tflag_d = 1'b1;
      sum_d   = '0;
      cnt_d   = '0;
      slot_d  = SW'(it_q.first_pos);
      mdvd_d  = XW'(ws_q) + XW'(1) + XW'(it_q.first_pos);
      mrem_d  = '0;
      mcnt_d  = MCW'(XW);
    end

    // Oldest slot by shift-subtract remainder
    if (cmd_i.mod_step) begin
      mrem_d = mt[LW-1:0];
      mdvd_d = mdvd_q << 1;
      mcnt_d = mcnt_q - MCW'(1);
      if (mcnt_q == MCW'(1)) slot_d = mt[SW-1:0];
    end

    // Walk one position
    if (cmd_i.acc) begin
      if (tflag_q) begin
        wtime_d = first_in ? trd_q : '1;
        tflag_d = 1'b0;
      end
      if (take) begin
        if (cnt_q == '0) begin
          mn_d = vval_q;
          mx_d = vval_q;
          fv_d = vval_q;
        end else begin
          if ($signed(vval_q) < $signed(mn_q)) mn_d = vval_q;
          if ($signed(mx_q) < $signed(vval_q)) mx_d = vval_q;
        end
        lv_d  = vval_q;
        sum_d = sum_q + $signed({{LW{vval_q[VAL_W-1]}}, vval_q});
        cnt_d = cnt_q + LW'(1);
      end
      pos_d  = pos_q + PW'(1);
      slot_d = slot_nxt;
    end

    // Signed average by restoring division of the magnitude
    if (cmd_i.div_init) begin
      dneg_d = sum_q[SUMW-1];
      ddvd_d = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
      drem_d = '0;
      dcnt_d = DCW'(SUMW);
    end
    if (cmd_i.div_step) begin
      drem_d = dt[LW-1:0];
      ddvd_d = {ddvd_q[SUMW-2:0], dge};
      dcnt_d = dcnt_q - DCW'(1);
    end

    // Result
    if (cmd_i.out_load) begin
      out_valid_d        = 1'b1;
      out_d.window_time  = wtime_q;
      out_d.stored_count = (closed_q < len) ? SCNT_W'(closed_q) : SCNT_W'(len);
      out_d.found        = cnt_q != '0;
      case (it_q.agg_kind)
        AGG_MIN:   out_d.result_value = mn_q;
        AGG_MAX:   out_d.result_value = mx_q;
        AGG_AVG:   out_d.result_value = avg;
        AGG_FIRST: out_d.result_value = fv_q;
        AGG_LAST:  out_d.result_value = lv_q;
        default: out_d.found = 1'b0;
      endcase
      if (!out_d.found) out_d.result_value = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q  <= HLEN_RST;
      ws_q        <= SW'(RST_LEN - 1);
      closed_q    <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) hist_len_q <= cfg_wdata_i;
      if (cmd_i.clear) clr_q <= clr_q + SW'(1);
      ws_q        <= ws_d;
      closed_q    <= closed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) it_q <= item_i;
    slot_q  <= slot_d;
    pos_q   <= pos_d;
    tflag_q <= tflag_d;
    mdvd_q  <= mdvd_d;
    mrem_q  <= mrem_d;
    mcnt_q  <= mcnt_d;
    sum_q   <= sum_d;
    cnt_q   <= cnt_d;
    mn_q    <= mn_d;
    mx_q    <= mx_d;
    fv_q    <= fv_d;
    lv_q    <= lv_d;
    ddvd_q  <= ddvd_d;
    drem_q  <= drem_d;
    dcnt_q  <= dcnt_d;
    dneg_q  <= dneg_d;
    wtime_q <= wtime_d;
    out_q   <= out_d;
  end

  // Valid row write: clear sweep, open, or store read-modify-write
  always_comb begin
    vwe     = cmd_i.clear || cmd_i.open || (cmd_i.store_wr && ent_ok);
    vaddr_w = ws_q;
    vdata_w = vrow_q | (ENTITIES'(1) << it_q.entity);
    if (cmd_i.clear) begin
      vaddr_w = clr_q;
      vdata_w = '0;
    end else if (cmd_i.open) begin
      vaddr_w = ws_nxt;
      vdata_w = '0;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (vwe) valid_mem[vaddr_w] <= vdata_w;
    if (cmd_i.clear) begin
      time_mem[clr_q] <= '1;
    end else if (cmd_i.open) begin
      time_mem[ws_nxt] <= it_q.timestamp;
    end
    if (cmd_i.store_rd && ent_ok) val_mem[vwaddr] <= it_q.sample_value;
  end

  // Memory reads
  always_ff @(posedge clk_i) begin
    vrow_q <= valid_mem[rd_slot];
    trd_q  <= time_mem[rd_slot];
    vval_q <= val_mem[vraddr];
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule
